[hdl/sfd_pkg.sv]
// shared types, codes and the lead byte table of the string frame decoder
`timescale 1ns / 1ps

package sfd_pkg;

    // header parsing phase, one-hot
    typedef enum logic [3:0] {
        PH_HEADER  = 4'b0001,
        PH_LEN_HI  = 4'b0010,
        PH_LEN_LO  = 4'b0100,
        PH_PAYLOAD = 4'b1000
    } t_phase;

    // status codes on the result
    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_BAD_HEADER  = 2'd1,
        ST_BAD_LEAD    = 2'd2,
        ST_UNUSED      = 2'd3
    } t_status;

    // header codes
    localparam logic [7:0] HDR_SHORT_MAX = 8'h1F;
    localparam logic [7:0] HDR_MED_MIN   = 8'h30;
    localparam logic [7:0] HDR_MED_MAX   = 8'h33;
    localparam logic [7:0] HDR_FINAL     = 8'h53;
    localparam logic [7:0] HDR_CHUNK     = 8'h52;

    // one result of the decoder
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       char_start;
        logic       string_done;
        t_status    status;
    } t_result;

    // byte count of a character from the top five bits of its lead byte, 0 if bad
    function automatic logic [2:0] lead_len(input logic [4:0] top);
        logic [2:0] len;
        case (top)
            5'h18, 5'h19, 5'h1A, 5'h1B: len = 3'd2;
            5'h1C, 5'h1D:               len = 3'd3;
            5'h1E:                      len = 3'd4;
            default: begin
                if (top[4] == 1'b0) begin
                    len = 3'd1;
                end else begin
                    len = 3'd0;
                end
            end
        endcase
        return len;
    endfunction

endpackage

[hdl/sfd_core.sv]
// decoder state and the per-byte step logic
`timescale 1ns / 1ps

module sfd_core
    import sfd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_byte,
    output t_result    o_res
);

    t_phase      r_phase,       n_phase;
    logic [15:0] r_chars_left,  n_chars_left;
    logic [1:0]  r_cont_left,   n_cont_left;
    logic        r_final_chunk, n_final_chunk;
    logic [7:0]  r_length_high, n_length_high;

    logic [2:0]  w_len;
    logic [15:0] w_chunk_len;

    assign w_len       = lead_len(i_byte[7:3]);
    assign w_chunk_len = {r_length_high, i_byte};

    always_comb begin
        n_phase       = r_phase;
        n_chars_left  = r_chars_left;
        n_cont_left   = r_cont_left;
        n_final_chunk = r_final_chunk;
        n_length_high = r_length_high;
        o_res.out_byte    = i_byte;
        o_res.out_valid   = 1'b0;
        o_res.char_start  = 1'b0;
        o_res.string_done = 1'b0;
        o_res.status      = ST_OK;

        case (r_phase)
            PH_LEN_HI: begin
                n_length_high = i_byte;
                n_phase       = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_chars_left = w_chunk_len;
                n_cont_left  = 2'd0;
                if (w_chunk_len != 16'd0) begin
                    n_phase = PH_PAYLOAD;
                end else begin
                    n_phase           = PH_HEADER;
                    o_res.string_done = r_final_chunk;
                end
            end
            PH_PAYLOAD: begin
                if (r_cont_left == 2'd0) begin
                    if (w_len == 3'd0) begin
                        o_res.status  = ST_BAD_LEAD;
                        n_phase       = PH_HEADER;
                        n_chars_left  = 16'd0;
                        n_cont_left   = 2'd0;
                        n_final_chunk = 1'b1;
                        n_length_high = 8'd0;
                    end else begin
                        o_res.out_valid  = 1'b1;
                        o_res.char_start = 1'b1;
                        n_chars_left     = r_chars_left - 16'd1;
                        n_cont_left      = 2'(w_len - 3'd1);
                        if (n_cont_left == 2'd0 && n_chars_left == 16'd0) begin
                            n_phase           = PH_HEADER;
                            o_res.string_done = r_final_chunk;
                        end
                    end
                end else begin
                    o_res.out_valid = 1'b1;
                    n_cont_left     = r_cont_left - 2'd1;
                    if (n_cont_left == 2'd0 && r_chars_left == 16'd0) begin
                        n_phase           = PH_HEADER;
                        o_res.string_done = r_final_chunk;
                    end
                end
            end
            default: begin
                if (i_byte <= HDR_SHORT_MAX) begin
                    n_final_chunk = 1'b1;
                    n_chars_left  = {8'd0, i_byte};
                    n_cont_left   = 2'd0;
                    if (i_byte != 8'd0) begin
                        n_phase = PH_PAYLOAD;
                    end else begin
                        n_phase           = PH_HEADER;
                        o_res.string_done = 1'b1;
                    end
                end else if (i_byte >= HDR_MED_MIN && i_byte <= HDR_MED_MAX) begin
                    n_final_chunk = 1'b1;
                    n_length_high = i_byte - HDR_MED_MIN;
                    n_phase       = PH_LEN_LO;
                end else if (i_byte == HDR_FINAL) begin
                    n_final_chunk = 1'b1;
                    n_phase       = PH_LEN_HI;
                end else if (i_byte == HDR_CHUNK) begin
                    n_final_chunk = 1'b0;
                    n_phase       = PH_LEN_HI;
                end else begin
                    o_res.status  = ST_BAD_HEADER;
                    n_phase       = PH_HEADER;
                    n_chars_left  = 16'd0;
                    n_cont_left   = 2'd0;
                    n_final_chunk = 1'b1;
                    n_length_high = 8'd0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HEADER;
            r_chars_left  <= 16'd0;
            r_cont_left   <= 2'd0;
            r_final_chunk <= 1'b1;
            r_length_high <= 8'd0;
        end else if (i_fire) begin
            r_phase       <= n_phase;
            r_chars_left  <= n_chars_left;
            r_cont_left   <= n_cont_left;
            r_final_chunk <= n_final_chunk;
            r_length_high <= n_length_high;
        end
    end

endmodule

[hdl/string_frame_decoder.sv]
// top level of the string frame decoder: input register, step logic, result register
`timescale 1ns / 1ps

// string frame decoder: takes a chunked, length-prefixed utf-8 string one byte
// per transfer and returns one result per byte, in order. header bytes (short,
// medium, final 'S' and non-final 0x52 chunk forms) give a character count;
// payload bytes pass through with out_valid set, char_start marks each lead byte
// and string_done marks the byte that ends the last character of a final chunk
// (or the last header byte of an empty final chunk). an unknown header code gives
// status 1 and a bad lead byte status 2; both send the decoder back to header
// parsing. one byte is taken per clock with no gaps while the result side is not
// stalling: a byte waits in the input register, the decoder state updates as it
// moves into the result register, and the result is offered from that register.
// o_stall only rises when both registers hold a transfer and the result side is
// stalling.

module string_frame_decoder
    import sfd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    // result channel
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_out_valid,
    output logic       o_char_start,
    output logic       o_string_done,
    output logic [1:0] o_status
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;

    logic       w_out_free;   // result register can load this cycle
    logic       w_move;       // byte moves from input register into result register
    logic       w_take;       // input transfer accepted
    t_result    w_res;

    assign w_out_free = !r_out_valid || !i_stall;
    assign w_move     = r_in_valid && w_out_free;
    assign o_stall    = r_in_valid && !w_out_free;
    assign w_take     = i_valid && !o_stall;

    // decoder state only advances when a byte leaves the input register
    sfd_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_move),
        .i_byte  (r_in_byte),
        .o_res   (w_res)
    );

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // payload, held while stalled
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_byte <= i_in_byte;
        end
        if (w_move) begin
            r_out <= w_res;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_out_byte    = r_out.out_byte;
    assign o_out_valid   = r_out.out_valid;
    assign o_char_start  = r_out.char_start;
    assign o_string_done = r_out.string_done;
    assign o_status      = r_out.status;

endmodule

[bench/tb.sv]
// testbench of the string frame decoder: byte stream driver, result monitor and predictor
`timescale 1ns / 1ps

module tb
    import sfd_pkg::*;
();

    // cycles with no transfer on either channel before the run is abandoned
    localparam int STALL_LIMIT = 1000;
    // bytes of stimulus, directed opening included
    localparam int STREAM_BYTES = 950;

    typedef struct {
        logic [7:0] data;
        bit         hold;     // pause here until every decoded result is back
    } t_stream_entry;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [7:0] i_in_byte = 8'h00;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [7:0] o_out_byte;
    logic       o_out_valid;
    logic       o_char_start;
    logic       o_string_done;
    logic [1:0] o_status;

    t_stream_entry stream_q[$];   // bytes still to be sent
    t_result       decoded_q[$];  // results owed by the block, oldest first
    int            n_items = 0;
    int            n_sent = 0;
    int            n_got = 0;
    int            n_err = 0;
    int            quiet_cycles = 0;

    // predictor state, matching the block just after reset
    t_phase        dec_phase = PH_HEADER;
    logic [15:0]   dec_chars = '0;
    logic [1:0]    dec_cont = '0;
    logic          dec_final = 1'b1;
    logic [7:0]    dec_len_hi = '0;

    string_frame_decoder uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_in_byte     (i_in_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_byte    (o_out_byte),
        .o_out_valid   (o_out_valid),
        .o_char_start  (o_char_start),
        .o_string_done (o_string_done),
        .o_status      (o_status)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // reset held low at the start, then released for good
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // utf-8 lead byte classes: 0 marks a byte that cannot start a character
    function automatic logic [2:0] char_bytes(input logic [7:0] b);
        casez (b)
            8'b0???????: return 3'd1;
            8'b110?????: return 3'd2;
            8'b1110????: return 3'd3;
            8'b11110???: return 3'd4;
            default:     return 3'd0;
        endcase
    endfunction

    // error recovery: everything back to the after-reset values
    function automatic void clear_decoder();
        dec_phase  = PH_HEADER;
        dec_chars  = '0;
        dec_cont   = '0;
        dec_final  = 1'b1;
        dec_len_hi = '0;
    endfunction

    // a chunk of n characters begins; an empty final chunk ends the string at once
    function automatic logic open_chunk(input logic [15:0] n);
        dec_chars = n;
        dec_cont  = '0;
        if (n != 16'd0) begin
            dec_phase = PH_PAYLOAD;
            return 1'b0;
        end
        dec_phase = PH_HEADER;
        return dec_final;
    endfunction

    // last byte of a character: the string ends if it was the last one of a final chunk
    function automatic logic close_char();
        if (dec_chars != 16'd0) begin
            return 1'b0;
        end
        dec_phase = PH_HEADER;
        return dec_final;
    endfunction

    // works out the result of one byte and moves the predictor state on
    task automatic decode_byte(input logic [7:0] b, output t_result r);
        logic [2:0] nbytes;
        r = '{out_byte: b, out_valid: 1'b0, char_start: 1'b0, string_done: 1'b0,
              status: ST_OK};
        case (dec_phase)
            PH_LEN_HI: begin
                dec_len_hi = b;
                dec_phase  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                r.string_done = open_chunk({dec_len_hi, b});
            end
            PH_PAYLOAD: begin
                if (dec_cont == 2'd0) begin
                    nbytes = char_bytes(b);
                    if (nbytes == 3'd0) begin
                        r.status = ST_BAD_LEAD;
                        clear_decoder();
                    end else begin
                        r.out_valid  = 1'b1;
                        r.char_start = 1'b1;
                        dec_chars    = dec_chars - 16'd1;
                        dec_cont     = 2'(nbytes - 3'd1);
                        if (dec_cont == 2'd0) begin
                            r.string_done = close_char();
                        end
                    end
                end else begin
                    r.out_valid = 1'b1;
                    dec_cont    = dec_cont - 2'd1;
                    if (dec_cont == 2'd0) begin
                        r.string_done = close_char();
                    end
                end
            end
            default: begin
                // header parsing, also for any phase code outside the four
                if (b <= HDR_SHORT_MAX) begin
                    dec_final     = 1'b1;
                    r.string_done = open_chunk({8'h00, b});
                end else if (b >= HDR_MED_MIN && b <= HDR_MED_MAX) begin
                    dec_final  = 1'b1;
                    dec_len_hi = b - HDR_MED_MIN;
                    dec_phase  = PH_LEN_LO;
                end else if (b == HDR_FINAL) begin
                    dec_final = 1'b1;
                    dec_phase = PH_LEN_HI;
                end else if (b == HDR_CHUNK) begin
                    dec_final = 1'b0;
                    dec_phase = PH_LEN_HI;
                end else begin
                    r.status = ST_BAD_HEADER;
                    clear_decoder();
                end
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    task automatic put_byte(input logic [7:0] b);
        stream_q.insert(stream_q.size(), '{data: b, hold: 1'b0});
        n_items++;
    endtask

    task automatic hold_for_results();
        stream_q.insert(stream_q.size(), '{data: 8'h00, hold: 1'b1});
    endtask

    // header of a chunk of n characters, in any form that can carry n
    task automatic put_header(input bit is_final, input int n);
        logic [15:0] len;
        len = 16'(n);
        if (!is_final) begin
            put_byte(HDR_CHUNK);
            put_byte(len[15:8]);
            put_byte(len[7:0]);
        end else if (n <= 31 && $urandom_range(0, 2) != 0) begin
            put_byte(len[7:0]);
        end else if (n <= 1023 && $urandom_range(0, 1) == 0) begin
            put_byte(HDR_MED_MIN + 8'(len[9:8]));
            put_byte(len[7:0]);
        end else begin
            put_byte(HDR_FINAL);
            put_byte(len[15:8]);
            put_byte(len[7:0]);
        end
    endtask

    // n characters of random width; now and then one lead byte is spoilt and the
    // string is cut short there, which sends the block back to header parsing
    task automatic put_chars(input int n, output bit broken);
        int brk;
        int width;
        broken = 1'b0;
        brk = ($urandom_range(0, 11) == 0) ? $urandom_range(0, n) : n + 1;
        for (int i = 0; i < n; i++) begin
            if (i == brk) begin
                put_byte(($urandom_range(0, 1) == 0) ? 8'h80 | 8'($urandom_range(0, 63))
                                                     : 8'hF8 | 8'($urandom_range(0, 7)));
                broken = 1'b1;
                return;
            end
            width = $urandom_range(1, 6);
            if (width > 4) begin
                width = 1;
            end
            case (width)
                1: put_byte(8'($urandom_range(0, 127)));
                2: put_byte(8'hC0 | 8'($urandom_range(0, 31)));
                3: put_byte(8'hE0 | 8'($urandom_range(0, 15)));
                default: put_byte(8'hF0 | 8'($urandom_range(0, 7)));
            endcase
            // continuation bytes are not checked by the block, so any value goes
            repeat (width - 1) begin
                put_byte(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                     : 8'h80 | 8'($urandom_range(0, 63)));
            end
        end
    endtask

    initial begin : stimulus
        logic [7:0] opening [27];
        logic [7:0] junk;
        int         n;
        int         pick;
        int         next_hold;
        bit         broken;

        opening = '{
            8'h00,                                      // empty final string
            8'h30, 8'h02, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, // medium form, 2 and 3 byte chars
            8'h52, 8'h00, 8'h00,                        // empty non-final chunk
            8'h53, 8'h00, 8'h01, 8'hF0, 8'h9F, 8'h98, 8'h80, // 'S' form, 4 byte char
            8'hFF,                                      // unknown header code
            8'h33, 8'hFF, 8'h7F, 8'hF8,                 // largest medium length, bad lead
            8'h52, 8'hFF, 8'hFF, 8'h80                  // largest chunk length, bad lead
        };
        foreach (opening[i]) begin
            put_byte(opening[i]);
        end
        hold_for_results();

        next_hold = STREAM_BYTES / 3;
        while (n_items < STREAM_BYTES) begin
            if ($urandom_range(0, 99) < 8) begin
                // stray unknown header code: the block drops it and stays in sync
                do begin
                    junk = 8'($urandom_range(8'h20, 8'hFF));
                end while ((junk >= HDR_MED_MIN && junk <= HDR_MED_MAX) ||
                           junk == HDR_FINAL || junk == HDR_CHUNK);
                put_byte(junk);
            end else begin
                broken = 1'b0;
                if ($urandom_range(0, 3) == 0) begin
                    repeat ($urandom_range(1, 2)) begin
                        if (!broken) begin
                            n = $urandom_range(0, 6);
                            put_header(1'b0, n);
                            put_chars(n, broken);
                        end
                    end
                end
                if (!broken) begin
                    pick = $urandom_range(0, 49);
                    if (pick == 0) begin
                        n = $urandom_range(200, 300);
                    end else if (pick < 5) begin
                        n = $urandom_range(20, 40);
                    end else begin
                        n = $urandom_range(0, 10);
                    end
                    put_header(1'b1, n);
                    put_chars(n, broken);
                end
            end
            // let the block drain completely now and then
            if (n_items >= next_hold) begin
                hold_for_results();
                next_hold += STREAM_BYTES / 3;
            end
        end
    end

    // ------------------------------------------------------------------
    // driver: one byte per transfer, random gaps by phase of the run
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive
        t_result       want;
        t_stream_entry head;
        bit            busy;
        int            snd_idle;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            busy = i_valid;
            if (i_valid && !o_stall) begin
                decode_byte(i_in_byte, want);
                decoded_q.insert(decoded_q.size(), want);
                n_sent++;
                busy = 1'b0;
            end
            if (n_sent * 3 < n_items) begin
                snd_idle = 23;
            end else if (n_sent * 3 < n_items * 2) begin
                snd_idle = 64;
            end else begin
                snd_idle = 0;
            end
            if (!busy) begin
                // a hold point is passed once nothing is owed any more
                if (stream_q.size() > 0 && stream_q[0].hold && decoded_q.size() == 0) begin
                    void'(stream_q.pop_front());
                end
                if (stream_q.size() > 0 && !stream_q[0].hold &&
                    $urandom_range(0, 99) >= snd_idle) begin
                    head = stream_q.pop_front();
                    i_valid   <= 1'b1;
                    i_in_byte <= head.data;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: checks each result transfer against the oldest prediction
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int got, input int want);
        n_err++;
        if (n_err <= 100) begin
            $display("result %0d: %s is %0d, predicted %0d", n_got, what, got, want);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        int      rcv_idle;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (decoded_q.size() == 0) begin
                    report_mismatch("unexpected transfer, byte", int'(o_out_byte), 0);
                end else begin
                    want = decoded_q.pop_front();
                    if (o_out_byte !== want.out_byte)
                        report_mismatch("out_byte", int'(o_out_byte), int'(want.out_byte));
                    if (o_out_valid !== want.out_valid)
                        report_mismatch("out_valid", int'(o_out_valid),
                                        int'(want.out_valid));
                    if (o_char_start !== want.char_start)
                        report_mismatch("char_start", int'(o_char_start),
                                        int'(want.char_start));
                    if (o_string_done !== want.string_done)
                        report_mismatch("string_done", int'(o_string_done),
                                        int'(want.string_done));
                    if (o_status !== want.status)
                        report_mismatch("status", int'(o_status), int'(want.status));
                end
                n_got++;
            end
            // receiver stalls heavily first, lightly second, never last
            if (n_got * 3 < n_items) begin
                rcv_idle = 64;
            end else if (n_got * 3 < n_items * 2) begin
                rcv_idle = 23;
            end else begin
                rcv_idle = 0;
            end
            i_stall <= ($urandom_range(0, 99) < rcv_idle);
        end
    end

    // ------------------------------------------------------------------
    // watchdog on cycles with no transfer at all
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == STALL_LIMIT) begin
            $display("string_frame_decoder: mismatch");
            $finish;
        end
    end

    // end of run: all bytes sent, all results back, then a short tail for strays
    initial begin : finish_run
        @(posedge i_rst_n);
        while (stream_q.size() != 0 || i_valid || decoded_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        if (n_err == 0) begin
            $display("string_frame_decoder: match");
        end else begin
            $display("string_frame_decoder: mismatch");
        end
        $finish;
    end

endmodule

[files.f]
hdl/sfd_pkg.sv
hdl/sfd_core.sv
hdl/string_frame_decoder.sv
bench/tb.sv
